// ===== rtl/srrw_pkg.sv =====
package srrw_pkg;

    // sequence numbers and window
    localparam int SEQ_W       = 4;
    localparam int SEQ_MODULUS = 10;
    localparam int WINDOW_SIZE = 5;
    localparam int SLOT_W      = $clog2(SEQ_MODULUS);

    // byte accounting
    localparam int TAG_W       = 16;
    localparam int LEN_W       = 10;
    localparam int TOTAL_W     = 31;
    localparam int PKT_W       = 22;
    localparam int CHUNK_BYTES = 1000;
    localparam int PROD_W      = PKT_W + $clog2(CHUNK_BYTES + 1);

    // completion burst
    localparam int FINAL_REPEATS = 10;
    localparam int REP_W         = $clog2(FINAL_REPEATS + 2);

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int KIND_W = 2;

    typedef logic [SEQ_W-1:0]   t_seq;
    typedef logic [TAG_W-1:0]   t_tag;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [TOTAL_W-1:0] t_total;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_FINAL   = 2'd2
    } t_kind;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } t_front_state;

    // one entry of the command queue: a single ack or release beat
    typedef struct packed {
        t_kind kind;
        t_seq  ack_seq;
        t_tag  tag;
        t_len  len;
        logic  finished;
        logic  last;
    } t_cmd;

    function automatic t_seq next_seq(input t_seq s);
        if (s == t_seq'(SEQ_MODULUS)) begin
            return t_seq'(1);
        end
        return s + t_seq'(1);
    endfunction

endpackage

// ===== rtl/srrw_if.sv =====
interface srrw_in_if;
    import srrw_pkg::*;

    logic valid;
    logic ready;
    t_seq seq_num;
    t_tag payload_tag;

    modport source (output valid, output seq_num, output payload_tag, input ready);
    modport sink   (input valid, input seq_num, input payload_tag, output ready);
endinterface

interface srrw_out_if;
    import srrw_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    t_seq              ack_seq;
    t_tag              release_tag;
    t_len              write_len;
    logic              finished;
    logic              last;

    modport source (output valid, output kind, output ack_seq, output release_tag,
                    output write_len, output finished, output last, input ready);
    modport sink   (input valid, input kind, input ack_seq, input release_tag,
                    input write_len, input finished, input last, output ready);
endinterface

// ===== rtl/selective_repeat_receive_window_unit.sv =====
// channel   dir  beat contents                                   handshake
// i_pkt     in   seq_num, payload_tag                            valid/ready
// o_res     out  kind, ack_seq, release_tag, write_len,          valid/ready
//                finished, last
// cfg       in   i_cfg_data (total_bytes)                        i_cfg_we, no wait
//
// the front pushes one command per ack-only packet and one per release, so an
// in-order packet that drains k held packets gives 1+k commands; the back sends
// one beat per cycle while o_res.ready is high, 1 to 15 beats per packet
// (a completing release adds a burst of ten final acks from the back's counter)
// synchronous reset puts the window front at 1, clears held flags, counters,
// total_bytes and the command queue; held handles are not reset
// the input stalls while the front drains held packets or the four-entry command
// queue is full, the back stalls only on o_res.ready; after completion packets
// are taken and dropped
module selective_repeat_receive_window_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    srrw_in_if.sink          i_pkt,
    srrw_out_if.source       o_res,
    input  logic             i_cfg_we,
    input  srrw_pkg::t_total i_cfg_data
);
    import srrw_pkg::*;

    // commands between front and back
    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_in, q_out;

    // classify packets, keep the window, do the byte accounting
    srrw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (i_pkt),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (q_in)
    );

    // short queue so each side can stall on its own
    srrw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty)
    );

    // turn commands into output beats, expand the final ack burst
    srrw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_out),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

// ===== rtl/srrw_front.sv =====
module srrw_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    srrw_in_if.sink                 i_pkt,
    input  logic                    i_cfg_we,
    input  srrw_pkg::t_total        i_cfg_data,
    input  logic                    i_full,
    output logic                    o_push,
    output srrw_pkg::t_cmd          o_cmd
);
    import srrw_pkg::*;

    t_front_state           r_state, n_state;
    t_seq                   r_front;
    logic [SEQ_MODULUS-1:0] r_valid;
    t_tag                   r_tag [SEQ_MODULUS];
    t_total                 r_bytes, n_bytes;
    logic [PKT_W-1:0]       r_pkts, n_pkts;
    logic [PROD_W-1:0]      r_prod, n_prod;
    logic                   r_done;
    t_total                 r_total;

    logic              w_ready;
    logic              is_rel;
    t_tag              rel_tag;
    logic [SLOT_W-1:0] cur_slot, nxt_slot, in_slot;
    t_seq              nf;
    t_total            remaining, len;
    logic              rel_done, more;
    logic              seq_hit, hold;
    logic [SEQ_W:0]    seq_gap;
    logic [PROD_W:0]   tot_ext;

    assign i_pkt.ready = w_ready;

    // release arithmetic, shared by input and held packets
    always_comb begin
        cur_slot  = SLOT_W'(r_front - t_seq'(1));
        nf        = next_seq(r_front);
        nxt_slot  = SLOT_W'(nf - t_seq'(1));
        remaining = (r_total > r_bytes) ? (r_total - r_bytes) : '0;
        len       = (remaining < t_total'(CHUNK_BYTES)) ? remaining : t_total'(CHUNK_BYTES);
        n_bytes   = r_bytes + len;
        if (r_pkts == {PKT_W{1'b1}}) begin
            n_pkts = r_pkts;
            n_prod = r_prod;
        end else begin
            n_pkts = r_pkts + 1'b1;
            n_prod = r_prod + PROD_W'(CHUNK_BYTES);
        end
        tot_ext  = (PROD_W+1)'(r_total);
        rel_done = (tot_ext <= {1'b0, n_prod}) &&
                   ((tot_ext + (PROD_W+1)'(CHUNK_BYTES)) > {1'b0, n_prod});
        more     = !rel_done && r_valid[nxt_slot];
    end

    // window test for out-of-order packets
    always_comb begin
        seq_hit = (i_pkt.seq_num == r_front);
        in_slot = SLOT_W'(i_pkt.seq_num - t_seq'(1));
        if ({1'b0, i_pkt.seq_num} >= {1'b0, r_front}) begin
            seq_gap = {1'b0, i_pkt.seq_num} - {1'b0, r_front};
        end else begin
            seq_gap = {1'b0, i_pkt.seq_num} + (SEQ_W+1)'(SEQ_MODULUS) - {1'b0, r_front};
        end
        hold = (i_pkt.seq_num != '0) && (i_pkt.seq_num <= t_seq'(SEQ_MODULUS)) &&
               (seq_gap < (SEQ_W+1)'(WINDOW_SIZE));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_pkt.valid && w_ready && !r_done && seq_hit && more) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_full && !more) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        w_ready = 1'b0;
        o_push  = 1'b0;
        is_rel  = 1'b0;
        rel_tag = r_tag[cur_slot];
        case (r_state)
            S_IDLE: begin
                w_ready = r_done || !i_full;
                rel_tag = i_pkt.payload_tag;
                if (i_pkt.valid && w_ready && !r_done) begin
                    o_push = 1'b1;
                    is_rel = seq_hit;
                end
            end
            S_DRAIN: begin
                o_push = !i_full;
                is_rel = !i_full;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase

        if (is_rel) begin
            o_cmd.kind     = KIND_RELEASE;
            o_cmd.ack_seq  = r_front;
            o_cmd.tag      = rel_tag;
            o_cmd.len      = LEN_W'(len);
            o_cmd.finished = rel_done;
            o_cmd.last     = !more;
        end else begin
            o_cmd.kind     = KIND_ACK;
            o_cmd.ack_seq  = i_pkt.seq_num;
            o_cmd.tag      = '0;
            o_cmd.len      = '0;
            o_cmd.finished = 1'b0;
            o_cmd.last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= t_seq'(1);
            r_valid <= '0;
            r_bytes <= '0;
            r_pkts  <= '0;
            r_prod  <= '0;
            r_done  <= 1'b0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
            if (is_rel) begin
                r_bytes <= n_bytes;
                r_pkts  <= n_pkts;
                r_prod  <= n_prod;
                r_front <= nf;
                r_done  <= rel_done;
                if (r_state == S_DRAIN) begin
                    r_valid[cur_slot] <= 1'b0;
                end
            end
            if (o_push && !is_rel && hold) begin
                r_valid[in_slot] <= 1'b1;
            end
        end
    end

    // held handles, no reset
    always_ff @(posedge i_clk) begin
        if (o_push && !is_rel && hold) begin
            r_tag[in_slot] <= i_pkt.payload_tag;
        end
    end

    a_no_push_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !o_push)
        else $error("command pushed after transfer completed");

    a_done_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_rel && rel_done) |=> (r_state == S_IDLE && r_done))
        else $error("completing release did not stop the drain");

    a_drain_slot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_valid[cur_slot])
        else $error("drain step on an empty slot");

endmodule

// ===== rtl/srrw_queue.sv =====
module srrw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srrw_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output srrw_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import srrw_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/srrw_back.sv =====
module srrw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srrw_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    srrw_out_if.source     o_res
);
    import srrw_pkg::*;

    logic             r_ovalid;
    t_kind            r_kind;
    t_seq             r_ack;
    t_tag             r_tag;
    t_len             r_len;
    logic             r_fin;
    logic             r_last;
    logic [REP_W-1:0] r_rep;
    t_seq             r_rep_seq;
    logic             load;

    assign load  = !r_ovalid || o_res.ready;
    assign o_pop = load && (r_rep == '0) && !i_empty;

    assign o_res.valid       = r_ovalid;
    assign o_res.kind        = r_kind;
    assign o_res.ack_seq     = r_ack;
    assign o_res.release_tag = r_tag;
    assign o_res.write_len   = r_len;
    assign o_res.finished    = r_fin;
    assign o_res.last        = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_rep    <= '0;
        end else if (load) begin
            if (r_rep != '0) begin
                r_ovalid <= 1'b1;
                r_rep    <= r_rep - 1'b1;
            end else if (!i_empty) begin
                r_ovalid <= 1'b1;
                if (i_cmd.kind == KIND_RELEASE && i_cmd.finished) begin
                    r_rep <= REP_W'(FINAL_REPEATS);
                end
            end else begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // beat payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_rep != '0) begin
                r_kind <= KIND_FINAL;
                r_ack  <= r_rep_seq;
                r_tag  <= '0;
                r_len  <= '0;
                r_fin  <= 1'b1;
                r_last <= (r_rep == REP_W'(1));
            end else if (!i_empty) begin
                r_kind    <= i_cmd.kind;
                r_ack     <= i_cmd.ack_seq;
                r_tag     <= i_cmd.tag;
                r_len     <= i_cmd.len;
                r_fin     <= i_cmd.finished;
                r_last    <= i_cmd.last && !(i_cmd.finished && (FINAL_REPEATS != 0));
                r_rep_seq <= i_cmd.ack_seq;
            end
        end
    end

    a_no_pop_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rep != '0) |-> !o_pop)
        else $error("queue popped during final ack burst");

    a_burst_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.kind == KIND_RELEASE && i_cmd.finished)
            |=> (r_rep == REP_W'(FINAL_REPEATS)))
        else $error("final ack burst not armed");

    a_burst_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rep != '0) |-> r_ovalid)
        else $error("burst pending without an output beat");

endmodule
